### src/xmodem_crc_packet_framer_assert.svh
// Assertion macros for the framer blocks.
`ifndef XMODEM_CRC_PACKET_FRAMER_ASSERT_SVH
`define XMODEM_CRC_PACKET_FRAMER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define XMCRC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define XMCRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/xmcrc_pkg.sv
package xmcrc_pkg;

    localparam int PACKET_BYTES = 128;
    localparam int CNT_W        = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int BURST_MAX    = 6;
    localparam int BURST_CNT_W  = 3;

    localparam logic [7:0]  SOH_BYTE = 8'h01;
    localparam logic [7:0]  EOT_BYTE = 8'h04;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] FIRST_SEQ_RESET = 8'd1;
    localparam logic [7:0] PAD_RESET       = 8'hFF;

    typedef enum logic [1:0] {
        MODE_DATA  = 2'd0,
        MODE_PAD   = 2'd1,
        MODE_EOT   = 2'd2,
        MODE_START = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_CRC     = 2'd2,
        KIND_EOT     = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_FIRST_SEQ = 1'b0,
        REG_PAD       = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] val;
        kind_t      kind;
        logic       status;
    } entry_t;

    typedef struct packed {
        entry_t [BURST_MAX-1:0]  ent;
        logic [BURST_CNT_W-1:0]  cnt;
    } burst_t;

    function automatic entry_t mk_entry(logic [7:0] val, kind_t kind, logic status);
        entry_t e;
        e.val    = val;
        e.kind   = kind;
        e.status = status;
        return e;
    endfunction

    // CRC-16/XMODEM over one byte, MSB first.
    function automatic logic [15:0] crc_step(logic [15:0] crc_in, logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/xmcrc_emit.sv
`include "xmodem_crc_packet_framer_assert.svh"

module xmcrc_emit
    import xmcrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  burst_t     burst,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [2:0] m_tuser,   // byte_kind[1:0], status[2]
    output logic       m_tlast
);

    entry_t [BURST_MAX-1:0] ent_reg, ent_next;
    logic [BURST_CNT_W-1:0] rem_reg, rem_next;
    logic take;
    logic last;

    assign m_tvalid = (rem_reg != '0);
    assign last     = (rem_reg == BURST_CNT_W'(1));
    assign take     = m_tvalid && m_tready;
    assign free     = !m_tvalid || (take && last);

    assign m_tdata  = ent_reg[0].val;
    assign m_tuser  = {ent_reg[0].status, ent_reg[0].kind};
    assign m_tlast  = last;

    always_comb begin
        ent_next = ent_reg;
        rem_next = rem_reg;
        if (load) begin
            ent_next = burst.ent;
            rem_next = burst.cnt;
        end else if (take) begin
            // advance the queue by one beat
            for (int i = 0; i < BURST_MAX - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
            rem_next = rem_reg - BURST_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    `XMCRC_ASSERT(a_load_only_when_free, aclk, aresetn, load |-> free, "burst loaded over pending beats")
    `XMCRC_ASSERT(a_load_shows, aclk, aresetn, load |=> m_tvalid, "loaded burst not presented")
    `XMCRC_ASSERT(a_drain, aclk, aresetn, (take && last && !load) |=> !m_tvalid, "valid held after last beat")
    `XMCRC_ASSERT(a_count_down, aclk, aresetn, (take && !last && !load) |=> (rem_reg == $past(rem_reg) - BURST_CNT_W'(1)), "beat count slipped")

endmodule

### src/xmodem_crc_packet_framer.sv
// Channel   | Direction | tdata     | tuser                         | tlast
// s_        | in        | data_byte | mode                          | -
// m_        | out       | out_byte  | byte_kind, status (bit 2)     | last_of_run
// APB       | in        | pwdata[7:0] -> first_sequence @0x0, pad_value @0x4
//
// One input beat is taken per cycle whenever the result queue is empty or its final beat
// leaves in the same cycle; the result beats then drain one per cycle while m_tready is high.
// A data or pad beat yields one result beat mid-packet, four at packet start, plus two CRC
// beats when it closes the packet; end yields one, start yields none. The output queue sets the rate.
// Reset (aresetn low, synchronous) clears the queue, packet count and CRC, sets the
// sequence number to 1, first_sequence to 1 and pad_value to 0xFF.
// A stall on m_tready holds the current beat and back-pressures s_tready.
`include "xmodem_crc_packet_framer_assert.svh"

module xmodem_crc_packet_framer
    import xmcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [1:0]  s_tuser,   // mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic [2:0]  m_tuser,   // byte_kind[1:0], status[2]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]       first_seq_reg;
    logic [7:0]       pad_reg;
    logic [7:0]       seq_reg, seq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      crc_reg, crc_next;

    logic        accept;
    logic        load;
    logic        free;
    burst_t      burst;
    mode_t       mode;
    logic [7:0]  payload;
    logic [15:0] crc_upd;
    logic        at_start;
    logic        full;
    reg_idx_t    cfg_idx;

    // Configuration port: always ready, register picked by paddr[2].
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign prdata  = (cfg_idx == REG_PAD) ? {24'h0, pad_reg} : {24'h0, first_seq_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_seq_reg <= FIRST_SEQ_RESET;
            pad_reg       <= PAD_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                REG_FIRST_SEQ: first_seq_reg <= pwdata[7:0];
                REG_PAD:       pad_reg       <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    assign s_tready = free;
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser);
    assign payload  = (mode == MODE_DATA) ? s_tdata : pad_reg;
    assign crc_upd  = crc_step(crc_reg, payload);
    assign at_start = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(PACKET_BYTES - 1));

    // Build the whole result burst, if any, for the accepted beat and the next framer state.
    always_comb begin
        seq_next  = seq_reg;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        load      = 1'b0;
        burst     = '0;
        if (accept) begin
            case (mode)
                MODE_START: begin
                    // drop any partial packet and restart numbering
                    seq_next = first_seq_reg;
                    cnt_next = '0;
                    crc_next = '0;
                end
                MODE_EOT: begin
                    load      = 1'b1;
                    burst.cnt = BURST_CNT_W'(1);
                    if (at_start) begin
                        burst.ent[0] = mk_entry(EOT_BYTE, KIND_EOT, 1'b0);
                    end else begin
                        // end in mid-packet: flag it, keep the packet open
                        burst.ent[0] = mk_entry(8'h00, KIND_EOT, 1'b1);
                    end
                end
                default: begin
                    load = 1'b1;
                    if (at_start) begin
                        burst.ent[0] = mk_entry(SOH_BYTE, KIND_HEADER, 1'b0);
                        burst.ent[1] = mk_entry(seq_reg, KIND_HEADER, 1'b0);
                        burst.ent[2] = mk_entry(8'hFF - seq_reg, KIND_HEADER, 1'b0);
                        burst.ent[3] = mk_entry(payload, KIND_PAYLOAD, 1'b0);
                        burst.ent[4] = mk_entry(crc_upd[15:8], KIND_CRC, 1'b0);
                        burst.ent[5] = mk_entry(crc_upd[7:0], KIND_CRC, 1'b0);
                        burst.cnt    = full ? BURST_CNT_W'(6) : BURST_CNT_W'(4);
                    end else begin
                        burst.ent[0] = mk_entry(payload, KIND_PAYLOAD, 1'b0);
                        burst.ent[1] = mk_entry(crc_upd[15:8], KIND_CRC, 1'b0);
                        burst.ent[2] = mk_entry(crc_upd[7:0], KIND_CRC, 1'b0);
                        burst.cnt    = full ? BURST_CNT_W'(3) : BURST_CNT_W'(1);
                    end
                    if (full) begin
                        // packet closes: clear count and CRC, advance sequence
                        cnt_next = '0;
                        crc_next = '0;
                        seq_next = seq_reg + 8'd1;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        crc_next = crc_upd;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= FIRST_SEQ_RESET;
            cnt_reg <= '0;
            crc_reg <= '0;
        end else begin
            seq_reg <= seq_next;
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
        end
    end

    xmcrc_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .burst    (burst),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `XMCRC_ASSERT(a_cnt_range, aclk, aresetn, {1'b0, cnt_reg} < (CNT_W+1)'(PACKET_BYTES), "packet byte count out of range")
    `XMCRC_ASSERT(a_start_clears, aclk, aresetn, (accept && mode == MODE_START) |=> (cnt_reg == '0 && crc_reg == 16'h0), "start did not clear packet")
    `XMCRC_ASSERT(a_eot_keeps, aclk, aresetn, (accept && mode == MODE_EOT) |=> (cnt_reg == $past(cnt_reg) && seq_reg == $past(seq_reg)), "end beat changed packet state")

endmodule
